// File: rtl/knn_bounded_max_heap_macros.svh
// Assertion macros for the k-nearest-neighbor heap block.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef KNN_BOUNDED_MAX_HEAP_MACROS_SVH
`define KNN_BOUNDED_MAX_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define KNN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KNN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KNN_ASSERT(lbl, clk, rst_n, prop, msg)
`define KNN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor heap block.
// No dependencies.
`timescale 1ns / 1ps
package knn_pkg;
  localparam int unsigned RowsDefault = 64;
  localparam int unsigned KDefault = 16;
  localparam int unsigned DistW = 32;
  localparam int unsigned IdxW = 16;
  localparam int unsigned RowW = 6;
  localparam logic [DistW-1:0] DistInf = '1;

  typedef enum logic {
    ActPush = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [RowW-1:0]  row_sel;
    logic [DistW-1:0] cand_distance;
    logic [IdxW-1:0]  cand_index;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] out_distance;
    logic [IdxW-1:0]  out_index;
    logic             accepted;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             is_read;
    logic             row_ok;
    logic [RowW-1:0]  row;
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
  } cmd_t;
endpackage

// File: rtl/knn_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on knn_pkg.
`timescale 1ns / 1ps
interface knn_in_if;
  logic             valid;
  logic             ready;
  knn_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface knn_out_if;
  logic              valid;
  logic              ready;
  knn_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/knn_front.sv
// Front end: accepts input beats, checks the row range and queues commands.
// Depends on knn_pkg and knn_if.
`timescale 1ns / 1ps
`include "knn_bounded_max_heap_macros.svh"
module knn_front #(
  parameter int unsigned ROWS = knn_pkg::RowsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  knn_in_if.sink         in_if,
  output logic           cmd_valid_o,
  output knn_pkg::cmd_t  cmd_o,
  input  logic           cmd_ready_i
);
  knn_pkg::cmd_t q_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  knn_pkg::cmd_t cmd_d;
  logic          push, pop;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready;
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rp_q];

  always_comb begin
    cmd_d.is_read = (in_if.data.action == knn_pkg::ActRead);
    cmd_d.row_ok = ({26'd0, in_if.data.row_sel} < 32'(ROWS));
    cmd_d.row = in_if.data.row_sel;
    cmd_d.distance = in_if.data.cand_distance;
    cmd_d.idx = in_if.data.cand_index;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `KNN_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3, "queue count out of range")
  `KNN_ASSERT(a_full_stall, clk_i, rst_ni, (cnt_q == 2'd2) |-> !in_if.ready, "push into full queue")
  `KNN_ASSERT(a_ptrs, clk_i, rst_ni, (cnt_q == 2'd0) |-> (wp_q == rp_q), "queue pointers disagree")
endmodule

// File: rtl/knn_back.sv
// Back end: heap store, sift-down for pushes, sorted readout by selection.
// Depends on knn_pkg and knn_if.
`timescale 1ns / 1ps
`include "knn_bounded_max_heap_macros.svh"
module knn_back #(
  parameter int unsigned ROWS = knn_pkg::RowsDefault,
  parameter int unsigned K = knn_pkg::KDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  knn_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  knn_out_if.source     out_if
);
  localparam int unsigned Depth = ROWS * K;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW = (K > 1) ? $clog2(K) : 1;
  localparam int unsigned CW = $clog2(K + 1);

  typedef enum logic [3:0] {
    StClear, StIdle, StRoot, StRootW, StChild, StChildW, StDecide,
    StRdReq, StRdWait, StOut
  } state_e;

  state_e state_q;
  logic [knn_pkg::DistW-1:0] dmem [Depth];
  logic [knn_pkg::IdxW-1:0]  pmem [Depth];
  logic [knn_pkg::DistW-1:0] rd_d_q;
  logic [knn_pkg::IdxW-1:0]  rd_p_q;
  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [knn_pkg::DistW-1:0] wd;
  logic [knn_pkg::IdxW-1:0]  wp;

  knn_pkg::cmd_t       cmd_q;
  logic [AW-1:0]       base_q, clr_q;
  logic [SW-1:0]       pos_q, c1_q, scan_q;
  logic [knn_pkg::DistW-1:0] c1d_q, rootd_q;
  logic [knn_pkg::IdxW-1:0]  c1p_q, rootp_q;
  logic                acc_q;
  logic [CW-1:0]       emitted_q;
  logic [knn_pkg::DistW-1:0] ld_q, bd_q;
  logic [SW-1:0]       ls_q, bs_q;
  logic [knn_pkg::IdxW-1:0]  bp_q;
  logic                have_last_q, found_q;
  knn_pkg::out_item_t  out_q;
  logic                ov_q;
  logic [SW:0]         c1w, c2w;
  logic                after_last;

  always_ff @(posedge clk_i) begin
    if (we) begin
      dmem[waddr] <= wd;
      pmem[waddr] <= wp;
    end
    rd_d_q <= dmem[raddr];
    rd_p_q <= pmem[raddr];
  end

  assign out_if.valid = ov_q;
  assign out_if.data = out_q;
  assign cmd_ready_o = (state_q == StIdle) && !ov_q;
  assign c1w = {pos_q, 1'b1};
  assign c2w = c1w + 1'b1;
  assign after_last = !have_last_q || (rd_d_q > ld_q) ||
                      ((rd_d_q == ld_q) && (scan_q > ls_q));

  always_comb begin
    we = 1'b0;
    waddr = base_q + AW'(pos_q);
    wd = cmd_q.distance;
    wp = cmd_q.idx;
    raddr = base_q + AW'(scan_q);
    unique case (state_q)
      StClear: begin
        we = 1'b1;
        waddr = clr_q;
        wd = knn_pkg::DistInf;
        wp = '0;
      end
      StIdle: raddr = AW'(cmd_i.row) * AW'(K);
      StDecide: begin
        if (c1d_q > cmd_q.distance && !(c1_q == pos_q)) begin
          we = 1'b1;
          wd = c1d_q;
          wp = c1p_q;
        end else begin
          we = 1'b1;
        end
      end
      StRoot: raddr = base_q + AW'(c1w[SW-1:0]);
      StRootW: raddr = base_q + AW'(c2w[SW-1:0]);
      StChild: raddr = base_q + AW'(c2w[SW-1:0]);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (ov_q && out_if.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Depth - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (cmd_valid_i && !ov_q) begin
            cmd_q <= cmd_i;
            base_q <= AW'(cmd_i.row) * AW'(K);
            pos_q <= '0;
            scan_q <= '0;
            emitted_q <= '0;
            have_last_q <= 1'b0;
            found_q <= 1'b0;
            if (!cmd_i.row_ok) begin
              state_q <= cmd_i.is_read ? StOut : StIdle;
              if (!cmd_i.is_read) begin
                ov_q <= 1'b1;
                out_q <= '{knn_pkg::DistInf, '0, 1'b0, 1'b1};
              end
            end else begin
              state_q <= cmd_i.is_read ? StRdReq : StRoot;
            end
          end
        end
        StRoot: begin
          if (cmd_q.distance > rd_d_q) begin
            ov_q <= 1'b1;
            out_q <= '{rd_d_q, rd_p_q, 1'b0, 1'b1};
            state_q <= StIdle;
          end else if (32'(c1w) >= 32'(K)) begin
            c1_q <= pos_q;
            state_q <= StDecide;
          end else begin
            state_q <= StRootW;
          end
        end
        StRootW, StChild: begin
          c1d_q <= rd_d_q;
          c1p_q <= rd_p_q;
          c1_q <= c1w[SW-1:0];
          state_q <= (32'(c2w) >= 32'(K)) ? StDecide : StChildW;
        end
        StChildW: begin
          if (rd_d_q > c1d_q) begin
            c1d_q <= rd_d_q;
            c1p_q <= rd_p_q;
            c1_q <= c2w[SW-1:0];
          end
          state_q <= StDecide;
        end
        StDecide: begin
          if (c1d_q > cmd_q.distance && !(c1_q == pos_q)) begin
            if (pos_q == '0) begin
              rootd_q <= c1d_q;
              rootp_q <= c1p_q;
            end
            pos_q <= c1_q;
            state_q <= StRoot;
          end else begin
            if (pos_q == '0) begin
              rootd_q <= cmd_q.distance;
              rootp_q <= cmd_q.idx;
            end
            ov_q <= 1'b1;
            out_q <= '{(pos_q == '0) ? cmd_q.distance : rootd_q,
                       (pos_q == '0) ? cmd_q.idx : rootp_q, 1'b1, 1'b1};
            state_q <= StIdle;
          end
        end
        StRdReq: state_q <= StRdWait;
        StRdWait: begin
          if (after_last && (!found_q || rd_d_q < bd_q)) begin
            found_q <= 1'b1;
            bd_q <= rd_d_q;
            bp_q <= rd_p_q;
            bs_q <= scan_q;
          end
          if (32'(scan_q) == 32'(K - 1)) begin
            state_q <= StOut;
          end else begin
            scan_q <= scan_q + 1'b1;
            state_q <= StRdReq;
          end
        end
        StOut: begin
          if (!ov_q) begin
            ov_q <= 1'b1;
            out_q <= '{cmd_q.row_ok ? bd_q : knn_pkg::DistInf,
                       cmd_q.row_ok ? bp_q : '0, 1'b0,
                       32'(emitted_q) == 32'(K - 1)};
            emitted_q <= emitted_q + 1'b1;
            have_last_q <= 1'b1;
            ld_q <= bd_q;
            ls_q <= bs_q;
            found_q <= 1'b0;
            scan_q <= '0;
            if (32'(emitted_q) == 32'(K - 1)) begin
              state_q <= StIdle;
            end else begin
              state_q <= cmd_q.row_ok ? StRdReq : StOut;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `KNN_ASSERT(a_out_hold, clk_i, rst_ni, (ov_q && !out_if.ready) |=> ov_q, "result dropped")
  `KNN_ASSERT(a_idle_ready, clk_i, rst_ni, cmd_ready_o |-> (state_q == StIdle), "ready busy")
  `KNN_ASSERT_NEVER(a_cnt, clk_i, rst_ni, 32'(emitted_q) > 32'(K), "readout overrun")
endmodule

// File: rtl/knn_bounded_max_heap.sv
// Top level of the k-nearest-neighbor bounded max-heap block.
// Depends on knn_pkg, knn_if, knn_front and knn_back.
`timescale 1ns / 1ps
// Each of ROWS rows keeps a K-entry max-heap of (distance, index) pairs in one
// memory with one write port and one registered read port. A push walks the heap
// level by level, with the child reads and the compare-write per level of the
// sift-down; a readout makes one memory read per slot for each result beat while
// selecting the next smallest pair. After reset a clearing pass over all ROWS*K
// entries fills the store before the first item is taken.
module knn_bounded_max_heap #(
  parameter int unsigned ROWS = knn_pkg::RowsDefault,
  parameter int unsigned K = knn_pkg::KDefault
) (
  input logic clk_i,
  input logic rst_ni,
  knn_in_if.sink    in_if,
  knn_out_if.source out_if
);
  logic          cmd_valid, cmd_ready;
  knn_pkg::cmd_t cmd;

  knn_front #(.ROWS(ROWS)) u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  knn_back #(.ROWS(ROWS), .K(K)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .out_if
  );
endmodule
